### rtl/lwam_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwam_pkg
// Shared widths and controller/datapath interface types for the latency
// window average and maximum block.
// ----------------------------------------------------------------------------
package lwam_pkg;

   // Latency sample and result field width
   localparam int LAT_W = 32;

   // One quotient bit per divider step
   localparam int DIV_STEPS = LAT_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // Commands from the controller to the datapath
   typedef struct packed {
      logic write;      // store the accepted sample, restart the scan
      logic rd;         // read the next history slot
      logic div_init;   // load the divider from the finished sums
      logic div_step;   // produce one quotient bit
      logic load;       // move the result into the output register
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic scan_last;  // read address is at the last slot
      logic count_zero; // no nonzero entry in the window
      logic out_free;   // output register can take a result now
   } status_type;

endpackage

### rtl/latency_window_average_max.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// latency_window_average_max
// Circular latency history with mean of the nonzero entries and window
// maximum, one result per sample.
// ----------------------------------------------------------------------------
//
//   channel  | dir | handshake              | payload
//   ---------+-----+------------------------+-------------------------------
//   req      | in  | req_tvalid/req_tready  | latency_us
//   rsp      | out | rsp_tvalid/rsp_tready  | average_latency, window_max
//
// Each sample passes from acceptance to result through one write, one memory
// read per slot during the scan, a drain and a check state, 32 divider steps
// and one load. With no nonzero slot the divider is skipped.
// The scan over the single-port history memory and the bit-serial divider set
// how long each sample takes. Reset is synchronous; a fill count marks
// unwritten slots, so no clearing pass follows reset. A stalled result sits
// in the output register; a new sample is accepted, and the next result waits
// only at load.
// ----------------------------------------------------------------------------
module latency_window_average_max #(
   parameter int WINDOW_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] latency_us
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata    // [31:0] average_latency, [63:32] window_max
);

   lwam_pkg::cmd_type    cmd;
   lwam_pkg::status_type status;

   logic [lwam_pkg::LAT_W-1:0] rsp_avg;
   logic [lwam_pkg::LAT_W-1:0] rsp_max;

   // Sequencer
   lwam_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid_i (req_tvalid),
      .req_ready_o (req_tready),
      .status_i    (status),
      .cmd_o       (cmd)
   );

   // History, accumulators, divider and result register
   lwam_datapath #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd_i       (cmd),
      .status_o    (status),
      .sample_i    (req_tdata),
      .rsp_valid_o (rsp_tvalid),
      .rsp_ready_i (rsp_tready),
      .rsp_avg_o   (rsp_avg),
      .rsp_max_o   (rsp_max)
   );

   assign rsp_tdata = {rsp_max, rsp_avg};

endmodule

### rtl/lwam_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwam_ctrl
// Sequencer: accept a sample, scan the history, run the divider unless the
// window holds no nonzero entry, then hand the result to the output register.
// ----------------------------------------------------------------------------
module lwam_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid_i,
   output logic                  req_ready_o,
   input  lwam_pkg::status_type  status_i,
   output lwam_pkg::cmd_type     cmd_o
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_CHECK,
      ST_DIV,
      ST_DONE
   } state_type;

   state_type                      state_ff, state_in;
   logic [lwam_pkg::DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;

   // Decode commands and next state
   always_comb begin
      state_in    = state_ff;
      div_cnt_in  = div_cnt_ff;
      cmd_o       = '0;
      req_ready_o = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready_o = 1'b1;
            if (req_valid_i) begin
               cmd_o.write = 1'b1;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd_o.rd = 1'b1;
            if (status_i.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (status_i.count_zero) begin
               state_in = ST_DONE;
            end else begin
               cmd_o.div_init = 1'b1;
               div_cnt_in     = '0;
               state_in       = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd_o.div_step = 1'b1;
            div_cnt_in     = div_cnt_ff + lwam_pkg::DIV_CNT_W'(1);
            if (div_cnt_ff == lwam_pkg::DIV_CNT_W'(lwam_pkg::DIV_STEPS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status_i.out_free) begin
               cmd_o.load = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and step count
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         div_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

endmodule

### rtl/lwam_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwam_datapath
// History memory, scan accumulators for sum, count and maximum, a radix-2
// restoring divider and the result register.
// ----------------------------------------------------------------------------
module lwam_datapath #(
   parameter int WINDOW_DEPTH = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  lwam_pkg::cmd_type           cmd_i,
   output lwam_pkg::status_type        status_o,
   input  logic [lwam_pkg::LAT_W-1:0]  sample_i,
   output logic                        rsp_valid_o,
   input  logic                        rsp_ready_i,
   output logic [lwam_pkg::LAT_W-1:0]  rsp_avg_o,
   output logic [lwam_pkg::LAT_W-1:0]  rsp_max_o
);

   localparam int LAT_W = lwam_pkg::LAT_W;
   localparam int IDX_W = $clog2(WINDOW_DEPTH);
   localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
   localparam int SUM_W = LAT_W + CNT_W;

   logic [LAT_W-1:0] mem_ff [WINDOW_DEPTH];

   logic [IDX_W-1:0] slot_ff;
   logic [CNT_W-1:0] fill_ff;
   logic [IDX_W-1:0] addr_ff;
   logic [LAT_W-1:0] rd_ff;
   logic [IDX_W-1:0] rd_idx_ff;
   logic             rd_valid_ff;
   logic [SUM_W-1:0] sum_ff;
   logic [CNT_W-1:0] count_ff;
   logic [LAT_W-1:0] max_ff;
   logic [CNT_W-1:0] rem_ff;
   logic [LAT_W-1:0] quo_ff;
   logic [LAT_W-1:0] held_ff;
   logic [LAT_W-1:0] rsp_avg_ff;
   logic [LAT_W-1:0] rsp_max_ff;
   logic             rsp_valid_ff;

   logic             entry_live;
   logic [CNT_W:0]   trial;
   logic [CNT_W:0]   trial_diff;
   logic             trial_ge;
   logic [LAT_W-1:0] avg_in;

   // Slots at or past the fill count were never written since reset: read as zero
   assign entry_live = (CNT_W'(rd_idx_ff) < fill_ff);

   // One restoring division step
   always_comb begin
      trial      = {rem_ff, quo_ff[LAT_W-1]};
      trial_diff = trial - {1'b0, count_ff};
      trial_ge   = (trial >= {1'b0, count_ff});
   end

   // Keep the previous mean when the window holds no nonzero entry
   assign avg_in = (count_ff == '0) ? held_ff : quo_ff;

   // History memory: write on accept, registered read during the scan
   always_ff @(posedge clock) begin
      if (cmd_i.write) begin
         mem_ff[slot_ff] <= sample_i;
      end
      if (cmd_i.rd) begin
         rd_ff <= mem_ff[addr_ff];
      end
   end

   // Write pointer, fill count and read pipeline valid
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff     <= '0;
         fill_ff     <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= cmd_i.rd;
         if (cmd_i.write) begin
            slot_ff <= (slot_ff == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : slot_ff + IDX_W'(1);
            if (fill_ff != CNT_W'(WINDOW_DEPTH)) begin
               fill_ff <= fill_ff + CNT_W'(1);
            end
         end
      end
   end

   // Scan address, accumulators and divider
   always_ff @(posedge clock) begin
      if (cmd_i.write) begin
         addr_ff  <= '0;
         sum_ff   <= '0;
         count_ff <= '0;
         max_ff   <= '0;
      end else begin
         if (cmd_i.rd) begin
            addr_ff   <= addr_ff + IDX_W'(1);
            rd_idx_ff <= addr_ff;
         end
         if (rd_valid_ff && entry_live && (rd_ff != '0)) begin
            sum_ff   <= sum_ff + SUM_W'(rd_ff);
            count_ff <= count_ff + CNT_W'(1);
            if (rd_ff > max_ff) begin
               max_ff <= rd_ff;
            end
         end
      end
      // Mean fits in LAT_W bits, so the upper sum bits start as the remainder
      if (cmd_i.div_init) begin
         rem_ff <= sum_ff[SUM_W-1:LAT_W];
         quo_ff <= sum_ff[LAT_W-1:0];
      end else if (cmd_i.div_step) begin
         rem_ff <= trial_ge ? trial_diff[CNT_W-1:0] : trial[CNT_W-1:0];
         quo_ff <= {quo_ff[LAT_W-2:0], trial_ge};
      end
   end

   // Held mean and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (cmd_i.load) begin
         held_ff      <= avg_in;
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready_i) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_i.load) begin
         rsp_avg_ff <= avg_in;
         rsp_max_ff <= max_ff;
      end
   end

   assign status_o.scan_last  = (addr_ff == IDX_W'(WINDOW_DEPTH - 1));
   assign status_o.count_zero = (count_ff == '0);
   assign status_o.out_free   = !rsp_valid_ff || rsp_ready_i;

   assign rsp_valid_o = rsp_valid_ff;
   assign rsp_avg_o   = rsp_avg_ff;
   assign rsp_max_o   = rsp_max_ff;

endmodule
